>>> rtl/hmpg_pkg.sv
// ============================================================================
// hmpg_pkg: shared types, constants and rhythm tables
// Command codes, the front-to-back item record, reset values of the
// configuration registers and the fixed on/off rhythm definitions.
// ============================================================================
package hmpg_pkg;

  // Configuration reset values and queue sizing
  localparam logic [15:0] CooldownReset = 16'd1000;
  localparam logic [19:0] MaxOnReset    = 20'd10000;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] FullDuty    = 8'd255;
  localparam logic [3:0] RhythmCount = 4'd11;

  // Command codes carried on the input tuser
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_PATTERN = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  // Record handed from the front part to the back part
  typedef struct packed {
    logic        acc;
    logic        dw;
    logic [7:0]  dd;
    logic        use_rhythm;
    logic [3:0]  rhythm;
    logic [31:0] elapsed;
    logic        running;
    logic        locked;
  } hmpg_rec_t;

  // Cycle length of a rhythm in ms
  function automatic logic [10:0] rhythm_mod(input logic [3:0] r);
    logic [10:0] m;
    case (r)
      4'd1:    m = 11'd180;
      4'd2:    m = 11'd900;
      4'd3:    m = 11'd1200;
      4'd4:    m = 11'd1400;
      4'd5:    m = 11'd1600;
      4'd6:    m = 11'd1400;
      4'd7:    m = 11'd700;
      4'd8:    m = 11'd1800;
      4'd9:    m = 11'd1000;
      4'd10:   m = 11'd1100;
      4'd11:   m = 11'd620;
      default: m = 11'd180;
    endcase
    return m;
  endfunction

  // floor(2^32 / cycle length); quotient estimate is exact or one low
  function automatic logic [31:0] rhythm_recip(input logic [3:0] r);
    logic [31:0] k;
    case (r)
      4'd1:    k = 32'd23860929;
      4'd2:    k = 32'd4772185;
      4'd3:    k = 32'd3579139;
      4'd4:    k = 32'd3067833;
      4'd5:    k = 32'd2684354;
      4'd6:    k = 32'd3067833;
      4'd7:    k = 32'd6135667;
      4'd8:    k = 32'd2386092;
      4'd9:    k = 32'd4294967;
      4'd10:   k = 32'd3904515;
      4'd11:   k = 32'd6927366;
      default: k = 32'd23860929;
    endcase
    return k;
  endfunction

  // On/off decision for phase p inside the rhythm cycle
  function automatic logic rhythm_on(input logic [3:0] r, input logic [10:0] p);
    logic        on;
    logic [21:0] third_prod;
    logic [11:0] third;
    third_prod = 22'(p) * 22'd683;     // p/3 exact for p < 1800
    third      = 12'(third_prod >> 11);
    case (r)
      4'd1:    on = p < 11'd140;
      4'd2:    on = p < 11'd260 || (p >= 11'd420 && p < 11'd680);
      4'd3:    on = p < 11'd180 || (p >= 11'd300 && p < 11'd480) ||
                    (p >= 11'd600 && p < 11'd1080);
      4'd4:    on = {1'b0, p} < 12'd200 + {3'b000, p[10:2]};
      4'd5:    on = p < 11'd180 || (p >= 11'd300 && p < 11'd480) ||
                    (p >= 11'd600 && p < 11'd780);
      4'd6:    on = p < 11'd700;
      4'd7:    on = p < 11'd420;
      4'd8:    on = {1'b0, p} < 12'd120 + third;
      4'd9:    on = p < 11'd180 || (p >= 11'd360 && p < 11'd540) ||
                    (p >= 11'd720 && p < 11'd900);
      4'd10:   on = p < 11'd780;
      4'd11:   on = p < 11'd390;
      default: on = 1'b0;
    endcase
    return on;
  endfunction

endpackage

>>> rtl/hmpg_front.sv
// ============================================================================
// hmpg_front: command decode and guard state
// Takes one command per cycle unless the queue is full, applies the
// start/stop/lockout rules and pushes a record (with elapsed time) to it.
// ============================================================================
module hmpg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic [31:0]       now_ms_i,
  input  logic [7:0]        duty_i,
  input  logic [3:0]        pattern_i,
  input  logic [31:0]       duration_ms_i,
  input  logic [15:0]       cooldown_ms_i,
  input  logic [19:0]       max_on_ms_i,
  output logic              push_o,
  input  logic              full_i,
  output hmpg_pkg::hmpg_rec_t rec_o
);
  import hmpg_pkg::*;

  logic        run_active_q, run_active_d;
  logic        lockout_q, lockout_d;
  logic        waived_q, waived_d;
  logic [31:0] start_time_q, start_time_d;
  logic [31:0] stop_time_q, stop_time_d;
  logic [19:0] run_limit_q, run_limit_d;
  logic [3:0]  rhythm_q, rhythm_d;

  logic        accept;
  logic [31:0] elapsed;
  logic [31:0] since_stop;
  logic        base_ok;
  logic        pat_ok;
  logic [7:0]  plain_duty;
  logic [19:0] capped;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  assign elapsed    = now_ms_i - start_time_q;
  assign since_stop = now_ms_i - stop_time_q;
  assign base_ok    = !lockout_q && (duration_ms_i != 32'd0) && !run_active_q &&
                      (waived_q || since_stop >= {16'd0, cooldown_ms_i});
  assign pat_ok     = (pattern_i >= 4'd1) && (pattern_i <= RhythmCount);
  assign plain_duty = (duty_i == 8'd0) ? 8'd1 : duty_i;
  assign capped     = (duration_ms_i > {12'd0, max_on_ms_i}) ? max_on_ms_i
                                                              : duration_ms_i[19:0];

  // Command decode and next state
  always_comb begin
    logic       acc;
    logic       dw;
    logic [7:0] dd;
    logic       use_r;
    acc          = 1'b0;
    dw           = 1'b0;
    dd           = 8'd0;
    use_r        = 1'b0;
    run_active_d = run_active_q;
    lockout_d    = lockout_q;
    waived_d     = waived_q;
    start_time_d = start_time_q;
    stop_time_d  = stop_time_q;
    run_limit_d  = run_limit_q;
    rhythm_d     = rhythm_q;
    case (cmd_e'(command_i))
      CMD_TICK: begin
        if (run_active_q) begin
          if (elapsed < {12'd0, run_limit_q}) begin
            if (rhythm_q != 4'd0) begin
              dw    = 1'b1;
              use_r = 1'b1;
            end
          end else begin
            dw           = 1'b1;
            run_active_d = 1'b0;
            stop_time_d  = now_ms_i;
            waived_d     = 1'b0;
            lockout_d    = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (base_ok) begin
          acc          = 1'b1;
          dw           = 1'b1;
          dd           = plain_duty;
          run_active_d = 1'b1;
          start_time_d = now_ms_i;
          run_limit_d  = capped;
          rhythm_d     = 4'd0;
        end
      end
      CMD_PATTERN: begin
        if (base_ok && pat_ok) begin
          acc          = 1'b1;
          dw           = 1'b1;
          dd           = FullDuty;
          run_active_d = 1'b1;
          start_time_d = now_ms_i;
          run_limit_d  = capped;
          rhythm_d     = pattern_i;
        end
      end
      CMD_STOP: begin
        dw = 1'b1;
        if (run_active_q) begin
          run_active_d = 1'b0;
          stop_time_d  = now_ms_i;
          waived_d     = 1'b0;
        end
      end
      CMD_CLEAR: begin
        lockout_d = 1'b0;
      end
      default: begin
      end
    endcase
    rec_o.acc        = acc;
    rec_o.dw         = dw;
    rec_o.dd         = dd;
    rec_o.use_rhythm = use_r;
    rec_o.rhythm     = rhythm_q;
    rec_o.elapsed    = elapsed;
    rec_o.running    = run_active_d;
    rec_o.locked     = lockout_d;
  end

  // Guard state, updated on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      lockout_q    <= 1'b0;
      waived_q     <= 1'b1;
      start_time_q <= 32'd0;
      stop_time_q  <= 32'd0;
      run_limit_q  <= 20'd0;
      rhythm_q     <= 4'd0;
    end else if (accept) begin
      run_active_q <= run_active_d;
      lockout_q    <= lockout_d;
      waived_q     <= waived_d;
      start_time_q <= start_time_d;
      stop_time_q  <= stop_time_d;
      run_limit_q  <= run_limit_d;
      rhythm_q     <= rhythm_d;
    end
  end

endmodule

>>> rtl/hmpg_fifo.sv
// ============================================================================
// hmpg_fifo: record queue between front and back
// Small circular buffer; push and pop may happen in the same cycle.
// ============================================================================
module hmpg_fifo #(
  parameter int unsigned Depth = hmpg_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hmpg_pkg::hmpg_rec_t wdata_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output hmpg_pkg::hmpg_rec_t rdata_o
);
  import hmpg_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  hmpg_rec_t       mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/hmpg_back.sv
// ============================================================================
// hmpg_back: rhythm phase pipeline and output register
// Three stages: quotient estimate by reciprocal, quotient times cycle length,
// then remainder correction, on/off lookup and the output register.
// ============================================================================
module hmpg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hmpg_pkg::hmpg_rec_t rec_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata
);
  import hmpg_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  hmpg_rec_t   rec1_q, rec2_q;
  logic [31:0] quot1_q;
  logic [31:0] qm2_q;
  logic [15:0] out_q;

  logic [63:0] est_prod;
  logic [31:0] qm_prod;
  logic [31:0] rem_raw;
  logic [11:0] rem0;
  logic [10:0] mod2;
  logic [11:0] rem1;
  logic [7:0]  duty3;

  // Stage advance chain
  assign rdy3       = !v3_q || m_axis_tready;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: quotient estimate
  assign est_prod = {32'd0, rec_i.elapsed} * {32'd0, rhythm_recip(rec_i.rhythm)};

  // Stage 2: estimate times cycle length
  assign qm_prod = quot1_q * {21'd0, rhythm_mod(rec1_q.rhythm)};

  // Stage 3: remainder below twice the cycle length, one correction step
  assign rem_raw = rec2_q.elapsed - qm2_q;
  assign rem0    = rem_raw[11:0];
  assign mod2    = rhythm_mod(rec2_q.rhythm);
  assign rem1    = (rem0 >= {1'b0, mod2}) ? rem0 - {1'b0, mod2} : rem0;
  assign duty3   = !rec2_q.use_rhythm ? rec2_q.dd :
                   (rhythm_on(rec2_q.rhythm, rem1[10:0]) ? FullDuty : 8'd0);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      rec1_q  <= rec_i;
      quot1_q <= est_prod[63:32];
    end
    if (rdy2 && v1_q) begin
      rec2_q <= rec1_q;
      qm2_q  <= qm_prod;
    end
    if (rdy3 && v2_q) begin
      out_q <= {4'd0, rec2_q.locked, rec2_q.running, duty3, rec2_q.dw, rec2_q.acc};
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> rtl/haptic_motor_pattern_guard.sv
// ============================================================================
// haptic_motor_pattern_guard: vibration motor guard top level
// Command stream in, one result per command out, APB register access.
// ============================================================================
// Usage:
//   s_axis carries commands: tuser is the command code, tdata the timestamp,
//   duty, pattern and duration. m_axis returns exactly one result per
//   command: accepted, drive write flag and duty, running and lockout flags.
//   The APB port holds cooldown_ms (0x0) and max_on_ms (0x4); write them
//   only while no command is in flight.
// Timing:
//   One command per cycle sustained while m_axis accepts results. A result
//   reaches m_axis via the record queue, the quotient and product registers
//   of the reciprocal-multiply phase pipeline and the output register.
//   Guard state is updated in the cycle a command is taken, so back-to-back
//   commands see each other's effect.
// Reset and stall:
//   Reset clears the run, lockout and queue, restores register defaults and
//   waives the first cooldown. A stalled m_axis fills the pipeline and then
//   the QueueDepth-entry queue, after which s_axis_tready drops.
// ============================================================================
module haptic_motor_pattern_guard #(
  parameter int unsigned QueueDepth = hmpg_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // now_ms[31:0], duty[39:32], pattern[43:40],
                                     // duration_ms[75:44], zero[79:76]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // accepted[0], drive_written[1], drive_duty[9:2],
                                     // running[10], locked_out[11], zero[15:12]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hmpg_pkg::*;

  logic [15:0] cooldown_q;
  logic [19:0] max_on_q;
  logic        cfg_wr;

  logic        push;
  logic        full;
  logic        q_valid;
  logic        q_pop;
  hmpg_rec_t   rec_in;
  hmpg_rec_t   rec_out;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {12'd0, max_on_q} : {16'd0, cooldown_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q <= CooldownReset;
      max_on_q   <= MaxOnReset;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        max_on_q <= pwdata[19:0];
      end else begin
        cooldown_q <= pwdata[15:0];
      end
    end
  end

  hmpg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .command_i     (s_axis_tuser),
    .now_ms_i      (s_axis_tdata[31:0]),
    .duty_i        (s_axis_tdata[39:32]),
    .pattern_i     (s_axis_tdata[43:40]),
    .duration_ms_i (s_axis_tdata[75:44]),
    .cooldown_ms_i (cooldown_q),
    .max_on_ms_i   (max_on_q),
    .push_o        (push),
    .full_i        (full),
    .rec_o         (rec_in)
  );

  hmpg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (rec_out)
  );

  hmpg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_pop),
    .rec_i         (rec_out),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> rtl/hmpg_checker.sv
// ============================================================================
// hmpg_port_checks: port-level checks for the motor guard
// Watches the result stream and flags results that break the guard rules.
// ============================================================================
module hmpg_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No duty reported without a drive write
  a_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[9:2] == 8'd0)
    else $error("duty without drive write");

  // An accepted start writes a nonzero duty and leaves the motor running
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tdata[1] && m_axis_tdata[10] && m_axis_tdata[9:2] != 8'd0)
    else $error("accepted start without running drive");

  // A start is never accepted under lockout
  a_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[11])
    else $error("start accepted while locked out");

endmodule

bind haptic_motor_pattern_guard hmpg_port_checks u_hmpg_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
